/* hdl/fpa_pkg.sv */
// Types, operation codes and helper functions for the fixed-point ALU.
// Used by fixed_point_alu; depends on nothing.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int QBITS     = 33;   // quotient bits kept by the divider pipe
  localparam int LATENCY   = 36;   // accept edge to the edge that ends the strobe

  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_CMP, FN_MIN, FN_MAX,
    FN_INC, FN_DEC, FN_TO_INT, FN_FROM_INT
  } func_t;

  typedef struct packed {
    logic              valid;
    logic [3:0]        func;
    logic [31:0]       res;
    logic              ovf;
    logic              dz;
    logic              eq;
    logic              lt;
    logic              gt;
    logic              neg;
    logic              big;
    logic [63:0]       prod;
    logic [63:0]       rem;
    logic [31:0]       den;
    logic [QBITS-1:0]  quo;
  } pipe_t;

  // Saturates a 33-bit signed sum to 32 bits; returns {ovf, value}.
  function automatic logic [32:0] clamp33(input logic [32:0] s);
    logic [32:0] r;
    if (s[32] != s[31]) begin
      r = {1'b1, (s[32] ? NEG_MIN : POS_MAX)};
    end else begin
      r = {1'b0, s[31:0]};
    end
    return r;
  endfunction

  // Sign and magnitude to a saturated 32-bit value; returns {ovf, value}.
  function automatic logic [32:0] from_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    logic [63:0] neg_mag;
    neg_mag = 64'd0 - mag;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, NEG_MIN};
      else                     r = {1'b0, neg_mag[31:0]};
    end else begin
      if (mag > 64'h7fff_ffff) r = {1'b1, POS_MAX};
      else                     r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  // One restoring division step producing quotient bit k.
  function automatic pipe_t div_step(input pipe_t p, input int k);
    pipe_t       n;
    logic [63:0] trial;
    n = p;
    trial = 64'(p.den) << k;
    if (p.rem >= trial) begin
      n.rem    = p.rem - trial;
      n.quo[k] = 1'b1;
    end
    return n;
  endfunction

endpackage

/* hdl/fixed_point_alu.sv */
// Top level of the signed fixed-point ALU: a fully pipelined datapath.
// Depends on fpa_pkg for types, codes and helper functions.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy
//   is always low: a new request may enter every cycle. func selects the
//   operation, operand_a and operand_b are raw signed values.
//   Each request yields one result. done is high for exactly one cycle while
//   result and the flags are valid; the receiver cannot stall, so the pipe
//   never waits.
//   done takes the same path for every operation. Throughput is one request
//   per cycle. The path is set by the divider: one register stage per
//   quotient bit, 33 of them, plus an input, a setup and an output stage. The
//   multiply is one 32x32 product registered in the setup stage.
//   Reset (rst, synchronous) clears every valid bit; requests in flight are
//   dropped and no done follows them.
module fixed_point_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic        done,
  output logic signed [31:0] result,
  output logic        is_equal,
  output logic        is_less,
  output logic        is_greater,
  output logic        overflow,
  output logic        div_by_zero
);
  import fpa_pkg::*;

  // input stage
  logic        s1_valid;
  logic [3:0]  s1_func;
  logic [31:0] s1_a;
  logic [31:0] s1_b;

  pipe_t prep;
  pipe_t dv [0:QBITS];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_func <= func;
    s1_a    <= operand_a;
    s1_b    <= operand_b;
  end

  // Setup: magnitudes, product, and all single-step operations.
  always_comb begin
    logic [31:0] maga;
    logic [31:0] magb;
    logic [63:0] num;
    logic [63:0] shl;
    logic [32:0] sat;
    logic        b_zero;
    maga   = s1_a[31] ? (32'd0 - s1_a) : s1_a;
    magb   = s1_b[31] ? (32'd0 - s1_b) : s1_b;
    num    = 64'(maga) << FRAC_BITS;
    b_zero = (s1_b == 32'd0);
    shl    = {{32{s1_a[31]}}, s1_a} << FRAC_BITS;
    sat    = 33'd0;

    prep       = '0;
    prep.valid = s1_valid;
    prep.func  = s1_func;
    prep.eq    = (s1_a == s1_b);
    prep.lt    = ($signed(s1_a) < $signed(s1_b));
    prep.gt    = ($signed(s1_a) > $signed(s1_b));
    prep.neg   = s1_a[31] ^ s1_b[31];
    prep.prod  = 64'(maga) * 64'(magb);
    prep.rem   = num;
    prep.den   = magb;
    // Quotient would need more than the kept bits: saturates for sure.
    prep.big   = !b_zero && ({2'b00, num} >= (66'(magb) << QBITS));

    unique case (s1_func)
      FN_ADD: sat = clamp33({s1_a[31], s1_a} + {s1_b[31], s1_b});
      FN_SUB: sat = clamp33({s1_a[31], s1_a} - {s1_b[31], s1_b});
      FN_INC: sat = clamp33({s1_a[31], s1_a} + 33'd1);
      FN_DEC: sat = clamp33({s1_a[31], s1_a} - 33'd1);
      FN_MIN: sat = {1'b0, prep.lt ? s1_a : s1_b};
      FN_MAX: sat = {1'b0, prep.gt ? s1_a : s1_b};
      FN_TO_INT: sat = {1'b0, 32'($signed(s1_a) >>> FRAC_BITS)};
      FN_FROM_INT: begin
        if (shl[63:31] != {33{shl[63]}}) sat = {1'b1, (shl[63] ? NEG_MIN : POS_MAX)};
        else                             sat = {1'b0, shl[31:0]};
      end
      FN_DIV: begin
        if (b_zero) begin
          prep.dz = 1'b1;
          sat = {1'b0, (s1_a[31] ? NEG_MIN : ((s1_a == 32'd0) ? 32'd0 : POS_MAX))};
        end
      end
      default: sat = 33'd0;
    endcase
    prep.ovf = sat[32];
    prep.res = sat[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= '0;
    end else begin
      dv[0] <= prep;
    end
  end

  // Divider pipe: stage i resolves quotient bit QBITS-1-i.
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= '0;
      end else begin
        dv[i+1] <= div_step(dv[i], QBITS - 1 - i);
      end
    end
  end

  // Final stage: rounding and saturation of multiply and divide.
  logic [32:0] fin;
  always_comb begin
    pipe_t       p;
    logic [63:0] qm;
    logic [63:0] qd;
    logic [32:0] rem2;
    p    = dv[QBITS];
    qm   = (p.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rem2 = {p.rem[31:0], 1'b0};
    qd   = 64'(p.quo) + 64'(rem2 >= 33'(p.den));
    fin  = {p.ovf, p.res};
    if (p.func == FN_MUL) begin
      fin = from_mag(p.neg, qm);
    end else if (p.func == FN_DIV && !p.dz) begin
      if (p.big) fin = {1'b1, (p.neg ? NEG_MIN : POS_MAX)};
      else       fin = from_mag(p.neg, qd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QBITS].valid;
    end
    result      <= fin[31:0];
    overflow    <= fin[32];
    div_by_zero <= dv[QBITS].dz;
    is_equal    <= dv[QBITS].eq;
    is_less     <= dv[QBITS].lt;
    is_greater  <= dv[QBITS].gt;
  end

  // Every result traces back to an accepted request a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching request");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (result == POS_MAX || result == NEG_MIN))
    else $error("overflow with an unsaturated result");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    (done && div_by_zero) |-> (!overflow &&
      (result == POS_MAX || result == NEG_MIN || result == 32'd0)))
    else $error("bad divide-by-zero result");

endmodule

/* bench/fixed_point_alu_test.sv */
// Self-checking bench for fixed_point_alu: directed corner cases, then random
// requests with random gaps, each result checked against a behavioral predictor.
// Depends on fpa_pkg and the fixed_point_alu RTL.
module fixed_point_alu_test;
  import fpa_pkg::*;

  typedef struct {
    logic [3:0]   func;
    logic [31:0]  a;
    logic [31:0]  b;
  } alu_req_t;

  typedef struct {
    logic [31:0] result;
    logic        eq;
    logic        lt;
    logic        gt;
    logic        ovf;
    logic        dz;
  } alu_res_t;

  localparam int MAX_CYCLES = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  func = 4'd0;
  logic signed [31:0] operand_a = 32'sd0;
  logic signed [31:0] operand_b = 32'sd0;
  logic        busy, done, is_equal, is_less, is_greater, overflow, div_by_zero;
  logic signed [31:0] result;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       errors = 0;
  int       cycle_count = 0;
  int       gap_left = 0;
  bit       stimulus_done = 1'b0;

  fixed_point_alu u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .operand_a(operand_a), .operand_b(operand_b), .done(done), .result(result),
    .is_equal(is_equal), .is_less(is_less), .is_greater(is_greater),
    .overflow(overflow), .div_by_zero(div_by_zero)
  );

  always #10 clk = ~clk;

  // Clamps a wide signed value to 32 bits, setting ovf when it saturates.
  function automatic logic [31:0] saturate(input logic signed [65:0] v, inout logic ovf);
    if (v > 66'sh7fff_ffff) begin
      ovf = 1'b1;
      return POS_MAX;
    end
    if (v < -66'sh8000_0000) begin
      ovf = 1'b1;
      return NEG_MIN;
    end
    return v[31:0];
  endfunction

  function automatic alu_res_t alu_predict(input alu_req_t q);
    alu_res_t r;
    logic signed [65:0] sa, sb, v;
    logic [65:0] ma, mb, prod, num, quo, rem;
    logic neg;
    sa = 66'(signed'(q.a));
    sb = 66'(signed'(q.b));
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    neg = (sa < 0) != (sb < 0);
    r.eq = sa == sb;
    r.lt = sa < sb;
    r.gt = sa > sb;
    r.ovf = 1'b0;
    r.dz = 1'b0;
    r.result = '0;
    case (q.func)
      FN_ADD:  r.result = saturate(sa + sb, r.ovf);
      FN_SUB:  r.result = saturate(sa - sb, r.ovf);
      FN_MUL: begin
        prod = (ma * mb + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        v = neg ? -$signed(prod) : $signed(prod);
        r.result = saturate(v, r.ovf);
      end
      FN_DIV: begin
        if (sb == 0) begin
          r.dz = 1'b1;
          r.result = sa > 0 ? POS_MAX : (sa < 0 ? NEG_MIN : 32'd0);
        end else begin
          num = ma << FRAC_BITS;
          quo = num / mb;
          rem = num % mb;
          if (rem >= mb - rem) quo = quo + 1;
          v = neg ? -$signed(quo) : $signed(quo);
          r.result = saturate(v, r.ovf);
        end
      end
      FN_MIN:      r.result = sa < sb ? q.a : q.b;
      FN_MAX:      r.result = sa > sb ? q.a : q.b;
      FN_INC:      r.result = saturate(sa + 1, r.ovf);
      FN_DEC:      r.result = saturate(sa - 1, r.ovf);
      FN_TO_INT:   r.result = 32'(sa >>> FRAC_BITS);
      FN_FROM_INT: r.result = saturate(sa * (66'sd1 <<< FRAC_BITS), r.ovf);
      default:     r.result = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] random_operand();
    logic [31:0] corners[8] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1,
                                32'hffff_ffff, 32'h100, 32'hffff_ff00, 32'h80};
    case ($urandom_range(0, 5))
      0: return corners[$urandom_range(0, 7)];
      1: return 32'(signed'($urandom_range(0, 4000)) - 2000);
      2: return 32'(signed'($urandom_range(0, 16'hffff)) - 32768);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [3:0] f, input logic [31:0] a, input logic [31:0] b);
    alu_req_t q;
    q.func = f;
    q.a = a;
    q.b = b;
    pending_reqs.push_back(q);
  endtask

  initial begin
    alu_req_t q;
    add_req(FN_ADD, POS_MAX, 32'd1);
    add_req(FN_ADD, NEG_MIN, 32'hffff_ffff);
    add_req(FN_SUB, NEG_MIN, 32'd1);
    add_req(FN_SUB, POS_MAX, 32'hffff_ffff);
    add_req(FN_MUL, POS_MAX, POS_MAX);
    add_req(FN_MUL, NEG_MIN, NEG_MIN);
    add_req(FN_MUL, 32'h180, 32'hffff_ff80);
    add_req(FN_MUL, 32'h1, 32'h80);
    add_req(FN_MUL, NEG_MIN, 32'h100);
    add_req(FN_DIV, 32'h100, 32'd0);
    add_req(FN_DIV, 32'hffff_ff00, 32'd0);
    add_req(FN_DIV, 32'd0, 32'd0);
    add_req(FN_DIV, NEG_MIN, 32'd1);
    add_req(FN_DIV, NEG_MIN, 32'hffff_ffff);
    add_req(FN_DIV, 32'd1, 32'd512);
    add_req(FN_CMP, 32'd5, 32'd5);
    add_req(FN_MIN, NEG_MIN, POS_MAX);
    add_req(FN_MAX, NEG_MIN, POS_MAX);
    add_req(FN_INC, POS_MAX, 32'd3);
    add_req(FN_DEC, NEG_MIN, 32'd3);
    add_req(FN_TO_INT, 32'hffff_ff01, 32'd0);
    add_req(FN_TO_INT, POS_MAX, 32'd0);
    add_req(FN_FROM_INT, 32'h0080_0000, 32'd0);
    add_req(FN_FROM_INT, 32'hff7f_ffff, 32'd0);
    add_req(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 1350; i++) begin
      q.func = $urandom_range(0, 14) < 13 ? 4'($urandom_range(0, 10)) : 4'($urandom_range(11, 15));
      q.a = random_operand();
      q.b = $urandom_range(0, 15) == 0 ? q.a : random_operand();
      pending_reqs.push_back(q);
    end
  end

  // Driver: hold start until accepted, then wait a random gap.
  always @(posedge clk) begin
    alu_req_t q;
    cycle_count <= cycle_count + 1;
    if (cycle_count == 9) rst <= 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(alu_predict('{func, operand_a, operand_b}));
      end
      if (start && busy) begin
        // keep the request on the ports
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        start <= 1'b1;
        func <= q.func;
        operand_a <= q.a;
        operand_b <= q.b;
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end else begin
        start <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    alu_res_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors = errors + 1;
      end else begin
        e = expected_results.pop_front();
        if ({e.result, e.eq, e.lt, e.gt, e.ovf, e.dz} !== {result, is_equal, is_less,
            is_greater, overflow, div_by_zero}) begin
          $display("%0t: expected result %h eq %b lt %b gt %b ovf %b dz %b", $time,
                   e.result, e.eq, e.lt, e.gt, e.ovf, e.dz);
          $display("%0t: actual   result %h eq %b lt %b gt %b ovf %b dz %b", $time,
                   result, is_equal, is_less, is_greater, overflow, div_by_zero);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    wait (stimulus_done && expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("fixed_point_alu regression: pass");
    end else begin
      $display("fixed_point_alu regression: fail");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= MAX_CYCLES);
    $display("%0t: timeout", $time);
    $display("fixed_point_alu regression: fail");
    $finish;
  end

endmodule

/* files.f */
hdl/fpa_pkg.sv
hdl/fixed_point_alu.sv
bench/fixed_point_alu_test.sv
